[hdl/four_port_pad_multiplexer_unit_macros.svh]
// ----------------------------------------------------------------------------
// four_port_pad_multiplexer_unit_macros
// assertion helpers for the pad multiplexer
// ----------------------------------------------------------------------------
`ifndef FOUR_PORT_PAD_MULTIPLEXER_UNIT_MACROS_SVH
`define FOUR_PORT_PAD_MULTIPLEXER_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define FPPM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define FPPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/fppm_pkg.sv]
// ----------------------------------------------------------------------------
// fppm_pkg
// shared types and constants of the pad multiplexer
// ----------------------------------------------------------------------------
`default_nettype none
package fppm_pkg;

	localparam int SLOTS = 4;
	localparam int BYTES_PER_SLOT = 8;
	localparam int BUF_LEN = SLOTS * BYTES_PER_SLOT;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int STEP_W = $clog2(BUF_LEN);
	localparam int BPOS_W = $clog2(BYTES_PER_SLOT);
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [1:0] KIND_HOST = 2'd0;
	localparam logic [1:0] KIND_REPLY = 2'd1;
	localparam logic [1:0] KIND_END = 2'd2;

	localparam logic RK_ANSWER = 1'b0;
	localparam logic RK_REQUEST = 1'b1;

	localparam logic CFG_ID = 1'b0;
	localparam logic CFG_STATUS = 1'b1;

	localparam logic [7:0] BYTE_CARD_SEL = 8'h81;
	localparam logic [7:0] BYTE_PAD_SEL = 8'h01;
	localparam logic [7:0] BYTE_CMD = 8'h42;
	localparam logic [7:0] BYTE_PAD_REQ = 8'h00;
	localparam logic [7:0] BYTE_FILL = 8'hFF;
	localparam logic [3:0] HI_CARD = 4'h8;
	localparam logic [3:0] HI_PAD = 4'h0;
	localparam logic [7:0] ID_RESET = 8'h80;
	localparam logic [7:0] STATUS_RESET = 8'h5A;

	typedef enum logic [2:0] {
		M_IDLE = 3'd0,
		M_CARD = 3'd1,
		M_CMD = 3'd2,
		M_SINGLE = 3'd3,
		M_ALL = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		P_NONE = 3'd0,
		P_CARD_SEL = 3'd1,
		P_PAD_SEL = 3'd2,
		P_CARD = 3'd3,
		P_CMD = 3'd4,
		P_REQ = 3'd5,
		P_SINGLE = 3'd6,
		P_ALL = 3'd7
	} pend_t;

	// one queued job: a single answer, a single request, or a broadcast
	// (requests to every slot but slot, then an answer)
	typedef struct packed {
		logic bcast;
		logic req;
		logic card;
		logic [SLOT_W-1:0] slot;
		logic [7:0] data;
		logic expect_rep;
		logic ack;
	} entry_t;

	typedef struct packed {
		logic kind;
		logic [7:0] host_data;
		logic host_ack;
		logic card;
		logic [1:0] slot;
		logic [7:0] dev_byte;
		logic expect_rep;
		logic last;
	} result_t;

	function automatic logic [1:0] slot2(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+1:0] w;
		w = {2'b00, s};
		return w[1:0];
	endfunction

endpackage
`default_nettype wire

[hdl/fppm_front.sv]
// ----------------------------------------------------------------------------
// fppm_front
// accepts input beats, runs the protocol state and emits queue jobs
// ----------------------------------------------------------------------------
`default_nettype none
module fppm_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [7:0] cfg_data,
	input wire logic acc,
	input wire logic [1:0] kind,
	input wire logic [7:0] data_byte,
	input wire logic reply_ack,
	output logic push,
	output fppm_pkg::entry_t push_entry
);

	fppm_pkg::mode_t mode_q, mode_n;
	fppm_pkg::pend_t pend_q, pend_n;
	logic [fppm_pkg::SLOT_W-1:0] slot_q, slot_n;
	logic [fppm_pkg::STEP_W-1:0] step_q, step_n;
	logic [fppm_pkg::BPOS_W-1:0] bpos_q, bpos_n;
	logic amq_q, amq_n;
	logic bad_q, bad_n;
	logic sfin_q, sfin_n;
	logic [7:0] id_q, status_q;
	logic [7:0] buf_q [fppm_pkg::BUF_LEN];

	logic buf_we;
	logic [7:0] buf_wd;
	logic [7:0] buf_rd;
	logic has_res;
	fppm_pkg::entry_t ent;

	// streaming position advance
	logic [fppm_pkg::STEP_W:0] step_inc;
	logic [fppm_pkg::BPOS_W:0] bpos_inc;
	logic adv_bwrap;
	logic [fppm_pkg::STEP_W-1:0] adv_step;
	logic [fppm_pkg::BPOS_W-1:0] adv_bpos;
	logic [fppm_pkg::SLOT_W-1:0] adv_slot;
	logic adv_ack;
	logic [3:0] nib;
	logic [fppm_pkg::SLOT_W-1:0] nslot;
	logic nib_ok;

	assign buf_rd = buf_q[step_q];

	always_comb begin
		step_inc = {1'b0, step_q} + 1'b1;
		bpos_inc = {1'b0, bpos_q} + 1'b1;
		adv_bwrap = (bpos_inc == (fppm_pkg::BPOS_W+1)'(fppm_pkg::BYTES_PER_SLOT));
		adv_bpos = adv_bwrap ? '0 : bpos_inc[fppm_pkg::BPOS_W-1:0];
		adv_step = (step_inc >= (fppm_pkg::STEP_W+1)'(fppm_pkg::BUF_LEN)) ? '0
			: step_inc[fppm_pkg::STEP_W-1:0];
		adv_slot = slot_q;
		adv_ack = 1'b1;
		if (adv_bwrap) begin
			if (slot_q == fppm_pkg::SLOT_W'(fppm_pkg::SLOTS - 1)) begin
				adv_slot = '0;
				adv_ack = 1'b0;
			end else begin
				adv_slot = slot_q + fppm_pkg::SLOT_W'(1);
			end
		end
	end

	assign nib = data_byte[3:0];
	assign nib_ok = (nib >= 4'd1) && (nib <= 4'(fppm_pkg::SLOTS));
	assign nslot = fppm_pkg::SLOT_W'(nib - 4'd1);

	always_comb begin
		mode_n = mode_q;
		pend_n = pend_q;
		slot_n = slot_q;
		step_n = step_q;
		bpos_n = bpos_q;
		amq_n = amq_q;
		bad_n = bad_q;
		sfin_n = sfin_q;
		buf_we = 1'b0;
		buf_wd = fppm_pkg::BYTE_FILL;
		has_res = 1'b0;
		ent = '0;
		case (kind)
			fppm_pkg::KIND_HOST: begin
				pend_n = fppm_pkg::P_NONE;
				has_res = 1'b1;
				case (mode_q)
					fppm_pkg::M_CARD: begin
						pend_n = fppm_pkg::P_CARD;
						ent.req = 1'b1;
						ent.card = 1'b1;
						ent.slot = slot_q;
						ent.data = data_byte;
						ent.expect_rep = 1'b1;
					end
					fppm_pkg::M_CMD: begin
						if (step_q == '0) begin
							step_n = fppm_pkg::STEP_W'(1);
							bpos_n = fppm_pkg::BPOS_W'(1);
							if (amq_q) begin
								bad_n = (data_byte != fppm_pkg::BYTE_CMD);
								ent.data = id_q;
								ent.ack = 1'b1;
							end else begin
								pend_n = fppm_pkg::P_CMD;
								ent.req = 1'b1;
								ent.slot = slot_q;
								ent.data = data_byte;
								ent.expect_rep = 1'b1;
							end
						end else begin
							step_n = '0;
							bpos_n = '0;
							amq_n = data_byte[0];
							if (amq_q) begin
								slot_n = '0;
								mode_n = fppm_pkg::M_ALL;
								ent.data = status_q;
								ent.ack = !bad_q;
							end else begin
								mode_n = fppm_pkg::M_SINGLE;
								pend_n = fppm_pkg::P_REQ;
								ent.req = 1'b1;
								ent.slot = slot_q;
								ent.data = fppm_pkg::BYTE_PAD_REQ;
								ent.expect_rep = 1'b1;
							end
						end
					end
					fppm_pkg::M_SINGLE: begin
						pend_n = fppm_pkg::P_SINGLE;
						ent.req = 1'b1;
						ent.slot = slot_q;
						ent.data = data_byte;
						ent.expect_rep = 1'b1;
					end
					fppm_pkg::M_ALL: begin
						if (sfin_q) begin
							buf_we = 1'b1;
							buf_wd = fppm_pkg::BYTE_FILL;
							step_n = adv_step;
							bpos_n = adv_bpos;
							slot_n = adv_slot;
							if (adv_bwrap) begin
								sfin_n = 1'b0;
							end
							ent.data = buf_rd;
							ent.ack = adv_ack;
						end else begin
							pend_n = fppm_pkg::P_ALL;
							ent.req = 1'b1;
							ent.slot = slot_q;
							ent.data = data_byte;
							ent.expect_rep = 1'b1;
						end
					end
					default: begin
						if (data_byte[7:4] == fppm_pkg::HI_CARD && nib_ok) begin
							slot_n = nslot;
							pend_n = fppm_pkg::P_CARD_SEL;
							ent.req = 1'b1;
							ent.card = 1'b1;
							ent.slot = nslot;
							ent.data = fppm_pkg::BYTE_CARD_SEL;
							ent.expect_rep = 1'b1;
						end else if (data_byte[7:4] == fppm_pkg::HI_PAD && nib_ok) begin
							slot_n = nslot;
							pend_n = fppm_pkg::P_PAD_SEL;
							ent.req = 1'b1;
							ent.slot = nslot;
							ent.data = fppm_pkg::BYTE_PAD_SEL;
							ent.expect_rep = 1'b1;
						end else begin
							ent.data = fppm_pkg::BYTE_FILL;
							ent.ack = 1'b0;
						end
					end
				endcase
			end
			fppm_pkg::KIND_REPLY: begin
				pend_n = fppm_pkg::P_NONE;
				ent.data = data_byte;
				ent.ack = reply_ack;
				has_res = (pend_q != fppm_pkg::P_NONE);
				case (pend_q)
					fppm_pkg::P_CARD_SEL: begin
						if (reply_ack) begin
							mode_n = fppm_pkg::M_CARD;
						end
					end
					fppm_pkg::P_PAD_SEL: begin
						if (reply_ack) begin
							mode_n = fppm_pkg::M_CMD;
							ent.bcast = amq_q;
							ent.slot = slot_q;
						end
					end
					fppm_pkg::P_CARD, fppm_pkg::P_SINGLE: begin
						if (!reply_ack) begin
							mode_n = fppm_pkg::M_IDLE;
						end
					end
					fppm_pkg::P_ALL: begin
						buf_we = 1'b1;
						buf_wd = data_byte;
						step_n = adv_step;
						bpos_n = adv_bpos;
						slot_n = adv_slot;
						sfin_n = adv_bwrap ? 1'b0 : !reply_ack;
						ent.data = buf_rd;
						ent.ack = adv_ack;
					end
					default: begin
					end
				endcase
			end
			fppm_pkg::KIND_END: begin
				mode_n = fppm_pkg::M_IDLE;
				slot_n = '0;
				step_n = '0;
				bpos_n = '0;
				sfin_n = 1'b0;
				pend_n = fppm_pkg::P_NONE;
			end
			default: begin
			end
		endcase
	end

	assign push = acc && has_res;
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= fppm_pkg::M_IDLE;
			pend_q <= fppm_pkg::P_NONE;
			slot_q <= '0;
			step_q <= '0;
			bpos_q <= '0;
			amq_q <= 1'b0;
			bad_q <= 1'b0;
			sfin_q <= 1'b0;
		end else if (acc) begin
			mode_q <= mode_n;
			pend_q <= pend_n;
			slot_q <= slot_n;
			step_q <= step_n;
			bpos_q <= bpos_n;
			amq_q <= amq_n;
			bad_q <= bad_n;
			sfin_q <= sfin_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q <= fppm_pkg::ID_RESET;
			status_q <= fppm_pkg::STATUS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fppm_pkg::CFG_ID: id_q <= cfg_data;
				fppm_pkg::CFG_STATUS: status_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// reply buffer, one byte written per streamed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fppm_pkg::BUF_LEN; i++) begin
				buf_q[i] <= fppm_pkg::BYTE_FILL;
			end
		end else if (acc && buf_we) begin
			buf_q[step_q] <= buf_wd;
		end
	end

endmodule
`default_nettype wire

[hdl/fppm_queue.sv]
// ----------------------------------------------------------------------------
// fppm_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module fppm_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire fppm_pkg::entry_t push_entry,
	input wire logic pop,
	output logic full,
	output logic valid,
	output fppm_pkg::entry_t head
);

	fppm_pkg::entry_t mem_q [fppm_pkg::QDEPTH];
	logic [fppm_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [fppm_pkg::QPTR_W:0] cnt_q;

	assign full = (cnt_q == (fppm_pkg::QPTR_W+1)'(fppm_pkg::QDEPTH));
	assign valid = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

[hdl/fppm_back.sv]
// ----------------------------------------------------------------------------
// fppm_back
// expands queued jobs into result beats into the output register
// ----------------------------------------------------------------------------
`default_nettype none
module fppm_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	input wire fppm_pkg::entry_t q_head,
	output logic pop,
	output logic out_valid,
	input wire logic out_ready,
	output fppm_pkg::result_t out_res
);

	logic [fppm_pkg::SLOT_W-1:0] k_q;
	logic valid_q;
	fppm_pkg::result_t res_q, res_n;
	logic load;
	logic final_beat;
	logic [fppm_pkg::SLOT_W-1:0] tgt;

	assign load = !valid_q || out_ready;
	assign final_beat = !q_head.bcast || (k_q == fppm_pkg::SLOT_W'(fppm_pkg::SLOTS - 1));
	assign pop = load && q_valid && final_beat;
	// broadcast skips the selected slot
	assign tgt = (k_q < q_head.slot) ? k_q : k_q + fppm_pkg::SLOT_W'(1);

	always_comb begin
		res_n = '0;
		if (q_head.bcast && !final_beat) begin
			res_n.kind = fppm_pkg::RK_REQUEST;
			res_n.slot = fppm_pkg::slot2(tgt);
			res_n.dev_byte = fppm_pkg::BYTE_PAD_SEL;
		end else if (q_head.req) begin
			res_n.kind = fppm_pkg::RK_REQUEST;
			res_n.card = q_head.card;
			res_n.slot = fppm_pkg::slot2(q_head.slot);
			res_n.dev_byte = q_head.data;
			res_n.expect_rep = q_head.expect_rep;
			res_n.last = 1'b1;
		end else begin
			res_n.kind = fppm_pkg::RK_ANSWER;
			res_n.host_data = q_head.data;
			res_n.host_ack = q_head.ack;
			res_n.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q <= '0;
		end else if (load) begin
			valid_q <= q_valid;
			if (q_valid) begin
				k_q <= final_beat ? '0 : k_q + fppm_pkg::SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_valid) begin
			res_q <= res_n;
		end
	end

	assign out_valid = valid_q;
	assign out_res = res_q;

endmodule
`default_nettype wire

[hdl/four_port_pad_multiplexer_unit.sv]
// The pad multiplexer takes one input beat per clock while its job queue
// (four entries) has room, and the back end sends one result beat per clock
// from its output register while m_tready is high. A host byte or a device
// reply to a pending request gives one result, a controller select
// acknowledged in all-controllers mode gives SLOTS results; the back-end
// expander, one beat per cycle while its output is taken, sets the sustained
// rate. The reply buffer is cleared by reset, with no clearing pass.
// ----------------------------------------------------------------------------
// four_port_pad_multiplexer_unit
// routes host serial bytes to controller and memory card ports
// ----------------------------------------------------------------------------
`default_nettype none
`include "four_port_pad_multiplexer_unit_macros.svh"
module four_port_pad_multiplexer_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [7:0] cfg_data,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [15:0] s_tdata, // data_byte[7:0], reply_ack[8], zero pad
	input wire logic [1:0] s_tuser, // kind[1:0]
	output logic m_tvalid,
	input wire logic m_tready,
	// host_data[7:0], host_ack[8], device_is_card[9], device_slot[11:10],
	// device_byte[19:12], reply_expected[20], zero pad
	output logic [23:0] m_tdata,
	output logic m_tuser, // result_kind
	output logic m_tlast
);

	logic acc;
	logic push, pop, q_full, q_valid;
	fppm_pkg::entry_t push_entry, q_head;
	fppm_pkg::result_t res;

	assign s_tready = !q_full;
	assign acc = s_tvalid && s_tready;

	fppm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.acc(acc),
		.kind(s_tuser),
		.data_byte(s_tdata[7:0]),
		.reply_ack(s_tdata[8]),
		.push(push),
		.push_entry(push_entry)
	);

	fppm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.full(q_full),
		.valid(q_valid),
		.head(q_head)
	);

	fppm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_head(q_head),
		.pop(pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res(res)
	);

	assign m_tdata = {3'b000, res.expect_rep, res.dev_byte, res.slot, res.card,
		res.host_ack, res.host_data};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

	`FPPM_ASSERT_NOW(a_answer_last, m_tvalid && (m_tuser == fppm_pkg::RK_ANSWER), m_tlast,
		"host answer not marked last")
	`FPPM_ASSERT_NOW(a_expect_last, m_tvalid && m_tdata[20], m_tlast,
		"expected reply on a non-final beat")
	`FPPM_ASSERT_NOW(a_req_no_host, m_tvalid && (m_tuser == fppm_pkg::RK_REQUEST),
		m_tdata[8:0] == 9'd0, "device request carries host fields")
	`FPPM_ASSERT_NEXT(a_bcast_cont, m_tvalid && m_tready && !m_tlast, m_tvalid,
		"broadcast run broken")

endmodule
`default_nettype wire
